// ===== rtl/wcsd_pkg.sv =====
// package with payload types, codes and walsh chip helper for the cdma spreader
`timescale 1ns / 1ps
`default_nettype none
package wcsd_pkg;

  localparam int CHIPS = 8;
  localparam int ROW_W = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 3;

  // symbol codes, anything else counts as idle
  localparam logic [1:0] SYM_ZERO = 2'd0;
  localparam logic [1:0] SYM_ONE  = 2'd1;
  localparam logic [1:0] SYM_IDLE = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW_A  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_B  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_C  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_D  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LISTEN = 3'd4;

  typedef struct packed {
    logic [1:0] sym_a;
    logic [1:0] sym_b;
    logic [1:0] sym_c;
    logic [1:0] sym_d;
  } in_item_t;

  typedef struct packed {
    logic signed [3:0] decision;
    logic              bit_taken;
    logic              letter_done;
    logic [7:0]        letter;
  } out_item_t;

  // chip is -1 when the row and chip index share an odd number of ones
  function automatic logic chip_is_neg(input logic [ROW_W-1:0] row,
                                       input logic [ROW_W-1:0] chip);
    chip_is_neg = ^(row & chip);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/walsh_cdma_spread_despread.sv =====
// four-station walsh spreader and single-station despreader with letter assembly
// an item accepted at in_ passes the input register, then the result register, to out_
// throughput: one item per cycle while the result is not stalled; the chip sum and
//   correlation tree sit between the regs
// in_stall only rises when both registers are full and the result is stalled
// reset (rst_n low, synchronous): both stages empty, rows 0,1,2,3, listen station a,
//   letter bits and bit position cleared
`timescale 1ns / 1ps
`default_nettype none
module walsh_cdma_spread_despread (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output      logic                               in_stall,
  input  wire wcsd_pkg::in_item_t                 in_item,
  output      logic                               out_valid,
  input  wire logic                               out_stall,
  output      wcsd_pkg::out_item_t                out_item,
  input  wire logic                               cfg_we,
  input  wire logic [wcsd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [wcsd_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import wcsd_pkg::*;

  // configuration
  logic [ROW_W-1:0] row_r [4];
  logic [1:0]       listen_r;

  // input stage
  logic       s1_valid_r;
  in_item_t   s1_item_r;

  // result stage
  logic       out_valid_r;
  out_item_t  out_item_r;

  // letter state
  logic [7:0] letter_bits_r, letter_bits_nxt;
  logic [3:0] bit_pos_r, bit_pos_nxt;

  logic       advance;
  logic       s1_load;
  out_item_t  result;

  // result register drains or is empty, so the input stage may move on
  assign advance   = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !advance;
  assign s1_load   = !in_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // config writes, beyond the list they fall through
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        row_r[i] <= ROW_W'(i);
      end
      listen_r <= 2'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROW_A:  row_r[0] <= cfg_data;
        REG_ROW_B:  row_r[1] <= cfg_data;
        REG_ROW_C:  row_r[2] <= cfg_data;
        REG_ROW_D:  row_r[3] <= cfg_data;
        REG_LISTEN: listen_r <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // spread, sum the channel, correlate with the listened row and decide
  always_comb begin
    logic [1:0]        sym [4];
    logic [ROW_W-1:0]  listen_row;
    logic signed [3:0] chip_sum;
    logic signed [6:0] corr;
    logic signed [6:0] corr_adj;
    logic signed [6:0] quot;
    logic              neg;
    logic [7:0]        mask;

    sym[0]     = s1_item_r.sym_a;
    sym[1]     = s1_item_r.sym_b;
    sym[2]     = s1_item_r.sym_c;
    sym[3]     = s1_item_r.sym_d;
    listen_row = row_r[listen_r];
    corr       = '0;

    for (int c = 0; c < CHIPS; c++) begin
      chip_sum = '0;
      for (int s = 0; s < 4; s++) begin
        neg = chip_is_neg(row_r[s], ROW_W'(c));
        if (sym[s] == SYM_ONE) begin
          chip_sum = neg ? chip_sum - 4'sd1 : chip_sum + 4'sd1;
        end else if (sym[s] == SYM_ZERO) begin
          chip_sum = neg ? chip_sum + 4'sd1 : chip_sum - 4'sd1;
        end
      end
      if (chip_is_neg(listen_row, ROW_W'(c))) begin
        corr = corr - 7'(chip_sum);
      end else begin
        corr = corr + 7'(chip_sum);
      end
    end

    // divide by the chip count, rounding toward zero
    corr_adj = corr[6] ? corr + 7'sd7 : corr;
    quot     = corr_adj >>> 3;

    result.decision    = quot[3:0];
    result.bit_taken   = 1'b0;
    result.letter_done = 1'b0;
    result.letter      = 8'd0;
    letter_bits_nxt    = letter_bits_r;
    bit_pos_nxt        = bit_pos_r;
    mask               = 8'h80 >> bit_pos_r[2:0];

    if (quot == 7'sd1 || quot == -7'sd1) begin
      // extra bits past the eighth are dropped
      if (bit_pos_r < 4'd8) begin
        letter_bits_nxt  = (quot == 7'sd1) ? (letter_bits_r | mask)
                                           : (letter_bits_r & ~mask);
        bit_pos_nxt      = bit_pos_r + 4'd1;
        result.bit_taken = 1'b1;
      end
    end else begin
      result.letter_done = 1'b1;
      result.letter      = letter_bits_r;
      bit_pos_nxt        = 4'd0;
    end
  end

  // pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      letter_bits_r <= 8'd0;
      bit_pos_r     <= 4'd0;
    end else begin
      if (s1_load) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
      if (advance && s1_valid_r) begin
        letter_bits_r <= letter_bits_nxt;
        bit_pos_r     <= bit_pos_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s1_load && in_valid) begin
      s1_item_r <= in_item;
    end
    if (advance && s1_valid_r) begin
      out_item_r <= result;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/walsh_cdma_spread_despread_chk.sv =====
// port-level checker for the walsh spreader, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module walsh_cdma_spread_despread_chk (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire wcsd_pkg::in_item_t  in_item,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire wcsd_pkg::out_item_t out_item
);
  import wcsd_pkg::*;

  // a stalled input item holds until taken
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_item))
    else $error("stalled input item changed");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  // emit and take are exclusive and follow the decision
  a_done_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.letter_done ==
                   !(out_item.decision == 4'sd1 || out_item.decision == -4'sd1))
                  && !(out_item.letter_done && out_item.bit_taken))
    else $error("letter_done does not match decision");

  // no letter shown without an emit
  a_letter_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.letter_done |-> out_item.letter == 8'd0)
    else $error("letter nonzero without letter_done");

  // reset empties the result stage
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind walsh_cdma_spread_despread walsh_cdma_spread_despread_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
`default_nettype wire

// ===== dv/tb_walsh_cdma_spread_despread.sv =====
// self-checking testbench for the four-station walsh cdma spreader and despreader
`timescale 1ns / 1ps
module tb_walsh_cdma_spread_despread;
  import wcsd_pkg::*;

  // run length and watchdog
  localparam int RANDOM_ITEMS = 1950;
  localparam int PHASE_ITEMS  = 150;
  localparam int CYCLE_LIMIT  = 600000;
  // slack after draining, give the block time to settle
  localparam int SETTLE_CYCLES = 4;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  walsh_cdma_spread_despread u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state: station rows, listened station, letter being built
  logic [ROW_W-1:0] model_row [4];
  logic [1:0]       model_listen;
  logic [7:0]       model_letter;
  logic [3:0]       model_bitpos;

  // results still owed by the block, oldest first
  out_item_t expected_q [$];

  int  fail_count = 0;
  int  reported_count = 0;
  int  items_sent = 0;
  int  phases_run = 0;
  int  letters_seen = 0;
  int  bits_seen = 0;
  int  bits_dropped = 0;
  int  cycle_count = 0;
  bit  send_idle = 1'b1;
  bit  rcv_idle = 1'b1;

  // chip sum of all stations, correlated with the listened row
  function automatic out_item_t predict_despread(input in_item_t it);
    logic [1:0]       syms [4];
    logic [2:0]       cidx;
    logic [ROW_W-1:0] lrow;
    int               corr;
    int               sum;
    int               chip;
    int               dec;
    out_item_t        res;
    syms[0] = it.sym_a;
    syms[1] = it.sym_b;
    syms[2] = it.sym_c;
    syms[3] = it.sym_d;
    lrow = model_row[model_listen];
    corr = 0;
    for (int c = 0; c < CHIPS; c++) begin
      cidx = c[2:0];
      sum = 0;
      for (int s = 0; s < 4; s++) begin
        chip = (^(model_row[s] & cidx)) ? -1 : 1;
        // code 3 falls through as idle
        if (syms[s] == SYM_ONE) sum += chip;
        else if (syms[s] == SYM_ZERO) sum -= chip;
      end
      corr += sum * ((^(lrow & cidx)) ? -1 : 1);
    end
    dec = corr / CHIPS;
    res = '0;
    res.decision = dec[3:0];
    if (dec == 1 || dec == -1) begin
      // bits past the eighth are dropped without touching the letter
      if (model_bitpos < 4'd8) begin
        model_letter[7 - model_bitpos] = (dec == 1);
        model_bitpos = model_bitpos + 4'd1;
        res.bit_taken = 1'b1;
      end
    end else begin
      // letter is emitted but not cleared
      res.letter_done = 1'b1;
      res.letter = model_letter;
      model_bitpos = '0;
    end
    return res;
  endfunction

  function automatic in_item_t make_item(input logic [1:0] a, input logic [1:0] b,
                                         input logic [1:0] c, input logic [1:0] d);
    in_item_t it;
    it.sym_a = a;
    it.sym_b = b;
    it.sym_c = c;
    it.sym_d = d;
    return it;
  endfunction

  function automatic logic [1:0] rand_sym();
    return 2'($urandom_range(0, 3));
  endfunction

  // one item: optional gap, then hold it until accepted
  task automatic send_item(input in_item_t it);
    int gap;
    gap = send_idle ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_q = {expected_q, predict_despread(it)};
    items_sent++;
  endtask

  // stop sending and wait until every owed result is back
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write, only called while the block is idle
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    // cfg_we low again before the next write
    @(posedge clk);
    case (idx)
      REG_ROW_A:  model_row[0] = val;
      REG_ROW_B:  model_row[1] = val;
      REG_ROW_C:  model_row[2] = val;
      REG_ROW_D:  model_row[3] = val;
      REG_LISTEN: model_listen = val[1:0];
      default: ;
    endcase
  endtask

  task automatic cfg_all(input logic [ROW_W-1:0] ra, input logic [ROW_W-1:0] rb,
                         input logic [ROW_W-1:0] rc, input logic [ROW_W-1:0] rd,
                         input logic [CFG_DATA_W-1:0] listen);
    cfg_write(REG_ROW_A, ra);
    cfg_write(REG_ROW_B, rb);
    cfg_write(REG_ROW_C, rc);
    cfg_write(REG_ROW_D, rd);
    cfg_write(REG_LISTEN, listen);
  endtask

  // reset rows 0..3 listening to a: station a alone, mixed items, all idle, code 3 as idle
  task automatic test_single_station();
    send_item(make_item(SYM_ONE, SYM_IDLE, SYM_IDLE, SYM_IDLE));
    send_item(make_item(SYM_ZERO, SYM_ONE, SYM_ONE, SYM_ONE));
    send_item(make_item(SYM_IDLE, SYM_IDLE, SYM_IDLE, SYM_IDLE));
    send_item(make_item(2'd3, SYM_ONE, SYM_ZERO, SYM_ONE));
    send_item(make_item(SYM_ONE, SYM_ONE, SYM_ONE, SYM_ONE));
  endtask

  // full letter, one bit too many, then a short letter over the old bits
  task automatic test_letter_assembly();
    logic [7:0] pattern;
    pattern = 8'hC5;
    for (int i = 7; i >= 0; i--) begin
      send_item(make_item(pattern[i] ? SYM_ONE : SYM_ZERO, rand_sym(), rand_sym(), rand_sym()));
    end
    // ninth bit must be dropped
    send_item(make_item(SYM_ZERO, rand_sym(), rand_sym(), rand_sym()));
    send_item(make_item(SYM_IDLE, SYM_ONE, SYM_ZERO, SYM_ONE));
    send_item(make_item(SYM_ZERO, SYM_IDLE, SYM_IDLE, SYM_IDLE));
    send_item(make_item(SYM_ZERO, SYM_ONE, SYM_ONE, SYM_ONE));
    send_item(make_item(2'd3, 2'd3, 2'd3, 2'd3));
  endtask

  // all stations on one row: decision reaches plus and minus four
  task automatic test_equal_rows();
    wait_drain();
    cfg_all(3'd7, 3'd7, 3'd7, 3'd7, {1'b0, REG_LISTEN[1:0] - 2'd1});
    send_item(make_item(SYM_ONE, SYM_ONE, SYM_ONE, SYM_ONE));
    send_item(make_item(SYM_ZERO, SYM_ZERO, SYM_ZERO, SYM_ZERO));
    send_item(make_item(SYM_ONE, SYM_ONE, SYM_ONE, SYM_ZERO));
    send_item(make_item(SYM_ZERO, SYM_ZERO, SYM_ZERO, SYM_IDLE));
  endtask

  // one random letter on the listened station, noise on the others, then the emit item
  task automatic send_letter();
    logic [1:0] syms [4];
    int         nbits;
    int         lst;
    lst = model_listen;
    nbits = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 11) : $urandom_range(1, 8);
    for (int b = 0; b <= nbits; b++) begin
      for (int s = 0; s < 4; s++) syms[s] = rand_sym();
      if (b < nbits) syms[lst] = 2'($urandom_range(0, 1));
      else syms[lst] = $urandom_range(0, 1) ? SYM_IDLE : 2'd3;
      // occasional fully random item
      if ($urandom_range(0, 9) == 0) begin
        for (int s = 0; s < 4; s++) syms[s] = rand_sym();
      end
      send_item(make_item(syms[0], syms[1], syms[2], syms[3]));
    end
  endtask

  // phases of random settings and letters, draining before every reconfiguration
  task automatic test_random_phases();
    int               target;
    int               phase_end;
    logic [ROW_W-1:0] perm [8];
    logic [ROW_W-1:0] tmp;
    int               j;
    logic [CFG_IDX_W-1:0] spare;
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      wait_drain();
      // idle patterns per phase, including stretches with no gaps at all
      send_idle = (phases_run % 4) != 1;
      rcv_idle  = (phases_run % 4) != 2 && (phases_run % 4) != 1;
      if (phases_run == 0) begin
        cfg_all(3'd7, 3'd6, 3'd5, 3'd0, 3'd3);
      end else if (phases_run == 1) begin
        cfg_all(3'd0, 3'd0, 3'd0, 3'd0, 3'd0);
      end else if ($urandom_range(0, 3) == 0) begin
        // rows may repeat, listen data with its upper bit set too
        cfg_all(3'($urandom), 3'($urandom), 3'($urandom), 3'($urandom), 3'($urandom));
      end else begin
        for (int k = 0; k < 8; k++) perm[k] = k[2:0];
        for (int k = 7; k > 0; k--) begin
          j = $urandom_range(0, k);
          tmp = perm[k];
          perm[k] = perm[j];
          perm[j] = tmp;
        end
        cfg_all(perm[0], perm[1], perm[2], perm[3], 3'($urandom));
      end
      // unused register indexes must be ignored
      if ($urandom_range(0, 2) == 0) begin
        spare = REG_LISTEN + 3'($urandom_range(1, 3));
        cfg_write(spare, 3'($urandom));
      end
      phases_run++;
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end && items_sent < target) send_letter();
    end
  endtask

  // result checker, receiver stalls drawn per item
  initial begin : result_check
    int        hold;
    out_item_t want;
    bit        bad;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      hold = rcv_idle ? $urandom_range(0, 17) : 0;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      if (out_item.letter_done) letters_seen++;
      if (out_item.bit_taken) bits_seen++;
      else if (!out_item.letter_done) bits_dropped++;
      if (expected_q.size() == 0) begin
        fail_count++;
        if (reported_count < 10) begin
          reported_count++;
          $display("unexpected result item: decision %0d taken %0b done %0b letter %02h",
                   out_item.decision, out_item.bit_taken, out_item.letter_done,
                   out_item.letter);
        end
      end else begin
        want = expected_q.pop_front();
        bad = (out_item.decision !== want.decision) || (out_item.bit_taken !== want.bit_taken) ||
              (out_item.letter_done !== want.letter_done) || (out_item.letter !== want.letter);
        if (bad) begin
          fail_count++;
          if (reported_count < 10) begin
            reported_count++;
            $display("mismatch: decision %0d/%0d taken %0b/%0b done %0b/%0b letter %02h/%02h",
                     want.decision, out_item.decision, want.bit_taken, out_item.bit_taken,
                     want.letter_done, out_item.letter_done, want.letter, out_item.letter);
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_q.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    // predictor mirrors the reset settings
    model_row[0] = 3'd0;
    model_row[1] = 3'd1;
    model_row[2] = 3'd2;
    model_row[3] = 3'd3;
    model_listen = 2'd0;
    model_letter = '0;
    model_bitpos = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_single_station();
    test_letter_assembly();
    test_equal_rows();
    test_random_phases();

    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_q.size() != 0) begin
      fail_count += expected_q.size();
      $display("%0d expected result items never arrived", expected_q.size());
    end
    $display("covered %0d items over %0d random setting phases plus directed cases",
             items_sent, phases_run);
    $display("%0d bits stored, %0d dropped past the eighth, %0d letters emitted, %0d failures",
             bits_seen, bits_dropped, letters_seen, fail_count);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
